@@ rtl/srt_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// srt_pkg
// shared types, codes and defaults of the sorted record table
// ----------------------------------------------------------------------------
package srt_pkg;

    localparam int MAX_ENTRIES_DEF  = 16;
    localparam int ISSUER_BYTES_DEF = 32;
    localparam int LABEL_BYTES_DEF  = 32;
    localparam int RECORD_BYTES_DEF = 128;

    localparam int FILL_W = 9;

    typedef enum logic [1:0] {
        KIND_BYTE   = 2'd0,
        KIND_REMOVE = 2'd1,
        KIND_READ   = 2'd2,
        KIND_CLEAR  = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_BAD_IDX = 2'd2,
        ST_LOCKED  = 2'd3
    } status_t;

    typedef struct packed {
        kind_t              kind;
        logic [3:0]         idx;
        logic [6:0]         off;
        logic [FILL_W-1:0]  fill;
    } cmd_t;

    typedef enum logic [3:0] {
        BK_IDLE,
        BK_EXEC,
        BK_CMP_RD,
        BK_CMP_EV,
        BK_SH_RD,
        BK_SH_WR,
        BK_CP_RD,
        BK_CP_WR,
        BK_RM_RD,
        BK_RM_WR,
        BK_RD_RD,
        BK_RD_OUT
    } back_state_t;

endpackage
`default_nettype wire

@@ rtl/srt_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// srt_front
// accepts items, stages record bytes and queues commands for the back end
// ----------------------------------------------------------------------------
module srt_front #(
    parameter int RECORD_BYTES = srt_pkg::RECORD_BYTES_DEF
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      accept,
    input  wire logic [1:0]                kind,
    input  wire logic [7:0]                data_byte,
    input  wire logic                      last_byte,
    input  wire logic [3:0]                entry_index,
    input  wire logic [6:0]                byte_offset,
    input  wire logic [$clog2(RECORD_BYTES)-1:0] stg_addr,
    output logic      [7:0]                stg_q,
    output logic                           push,
    output srt_pkg::cmd_t                  cmd
);

    localparam int BW = $clog2(RECORD_BYTES);

    logic [7:0]                  stg_mem [RECORD_BYTES];
    logic [srt_pkg::FILL_W-1:0]  fill_reg;
    logic [srt_pkg::FILL_W-1:0]  fill_next;
    logic [srt_pkg::FILL_W-1:0]  fill_inc;
    logic                        room;
    logic                        stg_we;

    assign room     = fill_reg < srt_pkg::FILL_W'(RECORD_BYTES);
    assign fill_inc = room ? fill_reg + srt_pkg::FILL_W'(1) : fill_reg;
    assign stg_we   = accept && (srt_pkg::kind_t'(kind) == srt_pkg::KIND_BYTE) && room;

    always_comb
    begin
        fill_next = fill_reg;
        push      = 1'b0;
        cmd.kind  = srt_pkg::kind_t'(kind);
        cmd.idx   = entry_index;
        cmd.off   = byte_offset;
        cmd.fill  = fill_inc;
        if (accept)
        begin
            case (srt_pkg::kind_t'(kind))
                srt_pkg::KIND_BYTE:
                begin
                    if (last_byte)
                    begin
                        push      = 1'b1;
                        fill_next = '0;
                    end
                    else
                    begin
                        fill_next = fill_inc;
                    end
                end
                srt_pkg::KIND_CLEAR:
                begin
                    push      = 1'b1;
                    fill_next = '0;
                end
                default:
                begin
                    push = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stg_we)
        begin
            stg_mem[fill_reg[BW-1:0]] <= data_byte;
        end
        stg_q <= stg_mem[stg_addr];
    end

endmodule
`default_nettype wire

@@ rtl/srt_cmd_fifo.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// srt_cmd_fifo
// two-entry command queue between front and back
// ----------------------------------------------------------------------------
module srt_cmd_fifo (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  srt_pkg::cmd_t       cmd_in,
    input  wire logic           pop,
    output srt_pkg::cmd_t       cmd_out,
    output logic                not_empty
);

    srt_pkg::cmd_t slot_reg [2];
    logic          wr_ptr_reg;
    logic          rd_ptr_reg;
    logic [1:0]    level_reg;
    logic          do_push;
    logic          do_pop;

    assign not_empty = level_reg != 2'd0;
    assign do_pop    = pop && not_empty;
    assign do_push   = push && (level_reg != 2'd2);
    assign cmd_out   = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            level_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            level_reg <= level_reg + 2'(do_push) - 2'(do_pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= cmd_in;
        end
    end

endmodule
`default_nettype wire

@@ rtl/srt_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// srt_back
// executes queued commands against the single-port entry store
// ----------------------------------------------------------------------------
module srt_back #(
    parameter int MAX_ENTRIES  = srt_pkg::MAX_ENTRIES_DEF,
    parameter int ISSUER_BYTES = srt_pkg::ISSUER_BYTES_DEF,
    parameter int LABEL_BYTES  = srt_pkg::LABEL_BYTES_DEF,
    parameter int RECORD_BYTES = srt_pkg::RECORD_BYTES_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             access_enabled,
    input  srt_pkg::cmd_t                         cmd_in,
    input  wire logic                             cmd_valid,
    output logic                                  cmd_pop,
    output logic [$clog2(RECORD_BYTES)-1:0]       stg_addr,
    input  wire logic [7:0]                       stg_q,
    output logic                                  active,
    output logic                                  done,
    output logic [1:0]                            status,
    output logic [3:0]                            position,
    output logic [7:0]                            read_byte,
    output logic [4:0]                            entry_count
);

    localparam int IW = $clog2(MAX_ENTRIES);
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int BW = $clog2(RECORD_BYTES);
    localparam int AW = $clog2(MAX_ENTRIES * RECORD_BYTES);
    localparam int FW = srt_pkg::FILL_W;

    localparam logic [FW-1:0] ISSUER_END = FW'(ISSUER_BYTES);
    localparam logic [FW-1:0] LABEL_END  = FW'(ISSUER_BYTES + LABEL_BYTES);
    localparam logic [BW-1:0] LAST_BYTE  = BW'(RECORD_BYTES - 1);

    srt_pkg::back_state_t state_reg, state_next;
    srt_pkg::cmd_t        cmd_reg, cmd_next;
    logic [CW-1:0]        cnt_reg, cnt_next;
    logic [IW-1:0]        e_reg, e_next;
    logic [IW-1:0]        i_reg, i_next;
    logic [IW-1:0]        pos_reg, pos_next;
    logic [BW-1:0]        b_reg, b_next;
    logic [BW-1:0]        j_reg, j_next;
    logic                 done_reg, done_next;
    logic [1:0]           status_reg, status_next;
    logic [3:0]           pos_out_reg, pos_out_next;
    logic [7:0]           rbyte_reg, rbyte_next;
    logic [4:0]           count_out_reg;

    logic [7:0]           mem [MAX_ENTRIES * RECORD_BYTES];
    logic [7:0]           mem_q;
    logic [7:0]           mem_wdata;
    logic                 mem_we;
    logic [AW-1:0]        mem_addr;
    logic [CW-1:0]        row_sel;
    logic [BW-1:0]        byte_sel;

    logic [7:0]           x_byte;
    logic [7:0]           cp_byte;
    logic [FW-1:0]        j_ext;
    logic                 idx_bad;
    logic                 off_bad;

    assign j_ext   = FW'(j_reg);
    assign x_byte  = (j_ext < cmd_reg.fill) ? stg_q : 8'd0;
    assign cp_byte = (FW'(b_reg) < cmd_reg.fill) ? stg_q : 8'd0;
    assign idx_bad = {{CW{1'b0}}, cmd_reg.idx} >= {4'd0, cnt_reg};
    assign off_bad = FW'(cmd_reg.off) >= FW'(RECORD_BYTES);
    assign mem_addr = AW'(row_sel * RECORD_BYTES) + AW'(byte_sel);
    assign active  = state_reg != srt_pkg::BK_IDLE;

    always_comb
    begin
        state_next   = state_reg;
        cmd_next     = cmd_reg;
        cnt_next     = cnt_reg;
        e_next       = e_reg;
        i_next       = i_reg;
        pos_next     = pos_reg;
        b_next       = b_reg;
        j_next       = j_reg;
        done_next    = 1'b0;
        status_next  = status_reg;
        pos_out_next = pos_out_reg;
        rbyte_next   = rbyte_reg;
        cmd_pop      = 1'b0;
        mem_we       = 1'b0;
        mem_wdata    = mem_q;
        row_sel      = CW'(e_reg);
        byte_sel     = b_reg;
        stg_addr     = b_reg;

        case (state_reg)
            srt_pkg::BK_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop    = 1'b1;
                    cmd_next   = cmd_in;
                    state_next = srt_pkg::BK_EXEC;
                end
            end
            srt_pkg::BK_EXEC:
            begin
                status_next  = srt_pkg::ST_OK;
                pos_out_next = 4'd0;
                rbyte_next   = 8'd0;
                b_next       = '0;
                j_next       = '0;
                i_next       = '0;
                case (cmd_reg.kind)
                    srt_pkg::KIND_BYTE:
                    begin
                        if (!access_enabled)
                        begin
                            status_next = srt_pkg::ST_LOCKED;
                            done_next   = 1'b1;
                            state_next  = srt_pkg::BK_IDLE;
                        end
                        else if (cnt_reg == CW'(MAX_ENTRIES))
                        begin
                            status_next = srt_pkg::ST_FULL;
                            done_next   = 1'b1;
                            state_next  = srt_pkg::BK_IDLE;
                        end
                        else if (cnt_reg == '0)
                        begin
                            pos_next   = '0;
                            state_next = srt_pkg::BK_CP_RD;
                        end
                        else
                        begin
                            state_next = srt_pkg::BK_CMP_RD;
                        end
                    end
                    srt_pkg::KIND_REMOVE:
                    begin
                        if (!access_enabled)
                        begin
                            status_next = srt_pkg::ST_LOCKED;
                            done_next   = 1'b1;
                            state_next  = srt_pkg::BK_IDLE;
                        end
                        else if (idx_bad)
                        begin
                            status_next = srt_pkg::ST_BAD_IDX;
                            done_next   = 1'b1;
                            state_next  = srt_pkg::BK_IDLE;
                        end
                        else if (CW'(cmd_reg.idx) + CW'(1) == cnt_reg)
                        begin
                            cnt_next   = cnt_reg - CW'(1);
                            done_next  = 1'b1;
                            state_next = srt_pkg::BK_IDLE;
                        end
                        else
                        begin
                            e_next     = IW'(cmd_reg.idx);
                            state_next = srt_pkg::BK_RM_RD;
                        end
                    end
                    srt_pkg::KIND_READ:
                    begin
                        if (!access_enabled)
                        begin
                            status_next = srt_pkg::ST_LOCKED;
                            done_next   = 1'b1;
                            state_next  = srt_pkg::BK_IDLE;
                        end
                        else if (idx_bad || off_bad)
                        begin
                            status_next = srt_pkg::ST_BAD_IDX;
                            done_next   = 1'b1;
                            state_next  = srt_pkg::BK_IDLE;
                        end
                        else
                        begin
                            state_next = srt_pkg::BK_RD_RD;
                        end
                    end
                    default:
                    begin
                        cnt_next   = '0;
                        done_next  = 1'b1;
                        state_next = srt_pkg::BK_IDLE;
                    end
                endcase
            end
            srt_pkg::BK_CMP_RD:
            begin
                row_sel    = CW'(i_reg);
                byte_sel   = j_reg;
                stg_addr   = j_reg;
                state_next = srt_pkg::BK_CMP_EV;
            end
            srt_pkg::BK_CMP_EV:
            begin
                row_sel  = CW'(i_reg);
                byte_sel = j_reg;
                stg_addr = j_reg;
                if (x_byte != mem_q && x_byte < mem_q)
                begin
                    // record goes before entry i
                    pos_next   = i_reg;
                    e_next     = IW'(cnt_reg - CW'(1));
                    state_next = srt_pkg::BK_SH_RD;
                end
                else if (x_byte == mem_q && x_byte != 8'd0
                         && j_ext + FW'(1) != ISSUER_END && j_ext + FW'(1) != LABEL_END)
                begin
                    j_next     = j_reg + BW'(1);
                    state_next = srt_pkg::BK_CMP_RD;
                end
                else if (x_byte == mem_q && j_ext < ISSUER_END)
                begin
                    // issuers equal, go on to label
                    j_next     = BW'(ISSUER_BYTES);
                    state_next = srt_pkg::BK_CMP_RD;
                end
                else if (CW'(i_reg) + CW'(1) == cnt_reg)
                begin
                    pos_next   = IW'(cnt_reg);
                    state_next = srt_pkg::BK_CP_RD;
                end
                else
                begin
                    i_next     = i_reg + IW'(1);
                    j_next     = '0;
                    state_next = srt_pkg::BK_CMP_RD;
                end
            end
            srt_pkg::BK_SH_RD:
            begin
                row_sel    = CW'(e_reg);
                state_next = srt_pkg::BK_SH_WR;
            end
            srt_pkg::BK_SH_WR:
            begin
                row_sel   = CW'(e_reg) + CW'(1);
                mem_we    = 1'b1;
                mem_wdata = mem_q;
                if (b_reg == LAST_BYTE)
                begin
                    b_next = '0;
                    if (e_reg == pos_reg)
                    begin
                        state_next = srt_pkg::BK_CP_RD;
                    end
                    else
                    begin
                        e_next     = e_reg - IW'(1);
                        state_next = srt_pkg::BK_SH_RD;
                    end
                end
                else
                begin
                    b_next     = b_reg + BW'(1);
                    state_next = srt_pkg::BK_SH_RD;
                end
            end
            srt_pkg::BK_CP_RD:
            begin
                row_sel    = CW'(pos_reg);
                state_next = srt_pkg::BK_CP_WR;
            end
            srt_pkg::BK_CP_WR:
            begin
                row_sel   = CW'(pos_reg);
                mem_we    = 1'b1;
                mem_wdata = cp_byte;
                if (b_reg == LAST_BYTE)
                begin
                    cnt_next     = cnt_reg + CW'(1);
                    pos_out_next = 4'(pos_reg);
                    done_next    = 1'b1;
                    state_next   = srt_pkg::BK_IDLE;
                end
                else
                begin
                    b_next     = b_reg + BW'(1);
                    state_next = srt_pkg::BK_CP_RD;
                end
            end
            srt_pkg::BK_RM_RD:
            begin
                row_sel    = CW'(e_reg) + CW'(1);
                state_next = srt_pkg::BK_RM_WR;
            end
            srt_pkg::BK_RM_WR:
            begin
                row_sel   = CW'(e_reg);
                mem_we    = 1'b1;
                mem_wdata = mem_q;
                if (b_reg == LAST_BYTE)
                begin
                    b_next = '0;
                    if (CW'(e_reg) + CW'(2) == cnt_reg)
                    begin
                        cnt_next   = cnt_reg - CW'(1);
                        done_next  = 1'b1;
                        state_next = srt_pkg::BK_IDLE;
                    end
                    else
                    begin
                        e_next     = e_reg + IW'(1);
                        state_next = srt_pkg::BK_RM_RD;
                    end
                end
                else
                begin
                    b_next     = b_reg + BW'(1);
                    state_next = srt_pkg::BK_RM_RD;
                end
            end
            srt_pkg::BK_RD_RD:
            begin
                row_sel    = CW'(cmd_reg.idx);
                byte_sel   = BW'(cmd_reg.off);
                state_next = srt_pkg::BK_RD_OUT;
            end
            srt_pkg::BK_RD_OUT:
            begin
                rbyte_next = mem_q;
                done_next  = 1'b1;
                state_next = srt_pkg::BK_IDLE;
            end
            default:
            begin
                state_next = srt_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= srt_pkg::BK_IDLE;
            cnt_reg       <= '0;
            done_reg      <= 1'b0;
            count_out_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            done_reg      <= done_next;
            count_out_reg <= 5'(cnt_next);
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        e_reg       <= e_next;
        i_reg       <= i_next;
        pos_reg     <= pos_next;
        b_reg       <= b_next;
        j_reg       <= j_next;
        status_reg  <= status_next;
        pos_out_reg <= pos_out_next;
        rbyte_reg   <= rbyte_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= mem_wdata;
        end
        mem_q <= mem[mem_addr];
    end

    assign done        = done_reg;
    assign status      = status_reg;
    assign position    = pos_out_reg;
    assign read_byte   = rbyte_reg;
    assign entry_count = count_out_reg;

endmodule
`default_nettype wire

@@ rtl/sorted_record_table.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_record_table
// sorted table of fixed-size records keyed by issuer then label
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. A record byte without
// last_byte is staged at once and gives no result. Every other item gives one
// result, shown for a single cycle with done high; the receiver cannot stall
// it. All store traffic goes through one single-port memory: an insert
// compares key bytes, shifts the later entries up and copies the record in;
// a remove moves the later entries down. No clearing pass after reset is
// needed. cfg_ready is always high.
module sorted_record_table #(
    parameter int MAX_ENTRIES  = srt_pkg::MAX_ENTRIES_DEF,
    parameter int ISSUER_BYTES = srt_pkg::ISSUER_BYTES_DEF,
    parameter int LABEL_BYTES  = srt_pkg::LABEL_BYTES_DEF,
    parameter int RECORD_BYTES = srt_pkg::RECORD_BYTES_DEF
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    output logic            busy,
    input  wire logic [1:0] kind,
    input  wire logic [7:0] data_byte,
    input  wire logic       last_byte,
    input  wire logic [3:0] entry_index,
    input  wire logic [6:0] byte_offset,
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic       cfg_data,
    output logic            done,
    output logic [1:0]      status,
    output logic [3:0]      position,
    output logic [7:0]      read_byte,
    output logic [4:0]      entry_count
);

    logic                                 accept;
    logic                                 access_reg;
    logic                                 push;
    srt_pkg::cmd_t                        cmd_front;
    srt_pkg::cmd_t                        cmd_back;
    logic                                 cmd_valid;
    logic                                 cmd_pop;
    logic                                 back_active;
    logic [$clog2(RECORD_BYTES)-1:0]      stg_addr;
    logic [7:0]                           stg_q;

    assign accept    = start && !busy;
    assign busy      = cmd_valid || back_active;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            access_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            access_reg <= cfg_data;
        end
    end

    srt_front #(
        .RECORD_BYTES (RECORD_BYTES)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .kind        (kind),
        .data_byte   (data_byte),
        .last_byte   (last_byte),
        .entry_index (entry_index),
        .byte_offset (byte_offset),
        .stg_addr    (stg_addr),
        .stg_q       (stg_q),
        .push        (push),
        .cmd         (cmd_front)
    );

    srt_cmd_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .cmd_in    (cmd_front),
        .pop       (cmd_pop),
        .cmd_out   (cmd_back),
        .not_empty (cmd_valid)
    );

    srt_back #(
        .MAX_ENTRIES  (MAX_ENTRIES),
        .ISSUER_BYTES (ISSUER_BYTES),
        .LABEL_BYTES  (LABEL_BYTES),
        .RECORD_BYTES (RECORD_BYTES)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .access_enabled (access_reg),
        .cmd_in         (cmd_back),
        .cmd_valid      (cmd_valid),
        .cmd_pop        (cmd_pop),
        .stg_addr       (stg_addr),
        .stg_q          (stg_q),
        .active         (back_active),
        .done           (done),
        .status         (status),
        .position       (position),
        .read_byte      (read_byte),
        .entry_count    (entry_count)
    );

`ifndef SYNTHESIS
    a_busy_after_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !(srt_pkg::kind_t'(kind) == srt_pkg::KIND_BYTE && !last_byte))
        |=> busy)
        else $error("busy not raised after command item");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (32'(entry_count) <= MAX_ENTRIES || MAX_ENTRIES > 31))
        else $error("entry count above table size");

    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != srt_pkg::ST_OK) |-> (position == 4'd0 && read_byte == 8'd0))
        else $error("nonzero payload on error result");
`endif

endmodule
`default_nettype wire
